/* hdl/bssc_pkg.sv */
// shared types, widths, register codes and phase tables for the six-step commutator
// no dependencies
`default_nettype none

package bssc_pkg;

   localparam int PHASE_W   = 3;
   localparam int WINDING_W = 2;
   localparam int TIMER_W   = 8;
   localparam int COUNT_W   = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd5;
   localparam logic [PHASE_W-1:0] STEPS_PER_REV = 3'd6;

   // register index, taken from the word address
   localparam logic [0:0] REG_CONVERT_ENABLE = 1'b0;

   typedef logic [WINDING_W-1:0] winding_type;

   typedef struct packed {
      logic                action;
      logic                sense;
      logic [TIMER_W-1:0]  timer_count;
      logic [PHASE_W-1:0]  phase_value;
   } req_payload_type;

   typedef struct packed {
      winding_type         high_side;
      winding_type         low_side;
      winding_type         sensed_phase;
      logic                sense_rising;
      logic                commutated;
      logic                convert_request;
      logic [PHASE_W-1:0]  phase_now;
      logic [COUNT_W-1:0]  commutation_total;
      logic                interval_valid;
      logic [TIMER_W-1:0]  revolution_interval;
   } rsp_payload_type;

   // windings: 0 A, 1 B, 2 C
   function automatic winding_type high_side_of(input logic [PHASE_W-1:0] p);
      case (p)
         3'd0, 3'd1: high_side_of = 2'd0;
         3'd2, 3'd3: high_side_of = 2'd1;
         default:    high_side_of = 2'd2;
      endcase
   endfunction

   function automatic winding_type low_side_of(input logic [PHASE_W-1:0] p);
      case (p)
         3'd0:       low_side_of = 2'd1;
         3'd1, 3'd2: low_side_of = 2'd2;
         3'd3, 3'd4: low_side_of = 2'd0;
         default:    low_side_of = 2'd1;
      endcase
   endfunction

   function automatic winding_type sensed_of(input logic [PHASE_W-1:0] p);
      case (p)
         3'd0, 3'd3: sensed_of = 2'd2;
         3'd1, 3'd4: sensed_of = 2'd1;
         default:    sensed_of = 2'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

/* hdl/bssc_req_if.sv */
// valid/ready channel for commutator input beats
// depends on bssc_pkg
`default_nettype none

interface bssc_req_if;
   import bssc_pkg::*;

   logic                valid;
   logic                ready;
   logic                action;
   logic                sense;
   logic [TIMER_W-1:0]  timer_count;
   logic [PHASE_W-1:0]  phase_value;

   modport source (output valid, action, sense, timer_count, phase_value, input ready);
   modport sink   (input valid, action, sense, timer_count, phase_value, output ready);
endinterface

`default_nettype wire

/* hdl/bssc_rsp_if.sv */
// valid/ready channel for commutator result beats
// depends on bssc_pkg
`default_nettype none

interface bssc_rsp_if;
   import bssc_pkg::*;

   logic                valid;
   logic                ready;
   logic [WINDING_W-1:0] high_side;
   logic [WINDING_W-1:0] low_side;
   logic [WINDING_W-1:0] sensed_phase;
   logic                sense_rising;
   logic                commutated;
   logic                convert_request;
   logic [PHASE_W-1:0]  phase_now;
   logic [COUNT_W-1:0]  commutation_total;
   logic                interval_valid;
   logic [TIMER_W-1:0]  revolution_interval;

   modport source (output valid, high_side, low_side, sensed_phase, sense_rising, commutated,
                   convert_request, phase_now, commutation_total, interval_valid,
                   revolution_interval, input ready);
   modport sink   (input valid, high_side, low_side, sensed_phase, sense_rising, commutated,
                   convert_request, phase_now, commutation_total, interval_valid,
                   revolution_interval, output ready);
endinterface

`default_nettype wire

/* hdl/bldc_six_step_commutator.sv */
// top level of the six-step sensorless commutator: csr port, step logic, output skid
// depends on bssc_pkg, bssc_req_if, bssc_rsp_if, bssc_step
`default_nettype none

// usage
//  - req_ch carries one beat per comparator sample or forced phase load; a beat is
//    taken at a rising edge with valid and ready both high
//  - rsp_ch returns exactly one result beat for every request beat, in order
//  - the step is evaluated combinationally from the request beat and the current
//    commutation state, and lands in the result register at the accept edge, or in
//    the skid entry when the result register is full and the receiver is stalled
//  - throughput is one beat per cycle; the only limit is the output side
//  - a two-deep output (result register plus one skid entry) lets a beat be taken
//    while the previous result still waits; ready drops only when both are full,
//    so a stalled receiver holds the request side after one extra beat
//  - csr port: one register, convert_enable at byte address 0, written in the
//    apb access cycle; pready is tied high, reads return the register
//  - reset (synchronous) clears phase, commutation count, revolution step count,
//    timer mark, convert_enable and the output valids; no clearing pass is needed
//  - configuration is expected to change only while the block is idle
module bldc_six_step_commutator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   bssc_req_if.sink                             req_ch,
   bssc_rsp_if.source                           rsp_ch,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [bssc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [bssc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [bssc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import bssc_pkg::*;

   // csr register
   logic convert_enable_ff, convert_enable_in;
   logic csr_write;
   logic csr_hit;

   // request side
   req_payload_type req_beat;
   rsp_payload_type step_rsp;
   logic            req_fire;

   // output register and skid entry
   rsp_payload_type out_ff, out_in;
   rsp_payload_type skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;

   // csr decode: word address picks the register, byte lanes ignored
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == REG_CONVERT_ENABLE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      convert_enable_in = convert_enable_ff;
      if (csr_write && csr_hit) begin
         convert_enable_in = csr_pwdata[0];
      end
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata[0] = convert_enable_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         convert_enable_ff <= 1'b0;
      end else begin
         convert_enable_ff <= convert_enable_in;
      end
   end

   // request beat
   assign req_beat.action      = req_ch.action;
   assign req_beat.sense       = req_ch.sense;
   assign req_beat.timer_count = req_ch.timer_count;
   assign req_beat.phase_value = req_ch.phase_value;

   // skid entry free means there is room for one more result
   assign req_ch.ready = !skid_valid_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;

   bssc_step u_step (
      .clock          (clock),
      .reset          (reset),
      .fire           (req_fire),
      .req            (req_beat),
      .convert_enable (convert_enable_ff),
      .rsp            (step_rsp)
   );

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_ch.ready) begin
         // result register free or draining this cycle
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (req_fire) begin
            out_in       = step_rsp;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         // receiver stalled: park the new result in the skid entry
         skid_in       = step_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid               = out_valid_ff;
   assign rsp_ch.high_side           = out_ff.high_side;
   assign rsp_ch.low_side            = out_ff.low_side;
   assign rsp_ch.sensed_phase        = out_ff.sensed_phase;
   assign rsp_ch.sense_rising        = out_ff.sense_rising;
   assign rsp_ch.commutated          = out_ff.commutated;
   assign rsp_ch.convert_request     = out_ff.convert_request;
   assign rsp_ch.phase_now           = out_ff.phase_now;
   assign rsp_ch.commutation_total   = out_ff.commutation_total;
   assign rsp_ch.interval_valid      = out_ff.interval_valid;
   assign rsp_ch.revolution_interval = out_ff.revolution_interval;

endmodule

`default_nettype wire

/* hdl/bssc_step.sv */
// commutation state and single-pass step logic
// depends on bssc_pkg
`default_nettype none

module bssc_step (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire bssc_pkg::req_payload_type req,
   input  wire logic                     convert_enable,
   output bssc_pkg::rsp_payload_type     rsp
);
   import bssc_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PHASE_W-1:0] steps_ff, steps_in;
   logic [TIMER_W-1:0] mark_ff, mark_in;

   logic               comm;
   logic [PHASE_W-1:0] phase_adv;
   logic [PHASE_W-1:0] steps_inc;
   logic               ivalid;

   always_comb begin
      // even phase advances on high sample, odd on low
      comm      = !req.action && (req.sense == !phase_ff[0]);
      phase_adv = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 3'd1;

      if (req.action) begin
         phase_in = (req.phase_value <= PHASE_LAST) ? req.phase_value : phase_ff;
      end else if (comm) begin
         phase_in = phase_adv;
      end else begin
         phase_in = phase_ff;
      end

      count_in  = count_ff + {{(COUNT_W-1){1'b0}}, comm};
      steps_inc = steps_ff + {{(PHASE_W-1){1'b0}}, comm};
      ivalid    = (steps_inc == STEPS_PER_REV);
      steps_in  = ivalid ? '0 : steps_inc;
      mark_in   = ivalid ? req.timer_count : mark_ff;

      rsp.high_side           = high_side_of(phase_in);
      rsp.low_side            = low_side_of(phase_in);
      rsp.sensed_phase        = sensed_of(phase_in);
      rsp.sense_rising        = !phase_in[0];
      rsp.commutated          = comm;
      rsp.convert_request     = comm && convert_enable;
      rsp.phase_now           = phase_in;
      rsp.commutation_total   = count_in;
      rsp.interval_valid      = ivalid;
      rsp.revolution_interval = ivalid ? (req.timer_count - mark_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         count_ff <= '0;
         steps_ff <= '0;
         mark_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         steps_ff <= steps_in;
         mark_ff  <= mark_in;
      end
   end

endmodule

`default_nettype wire
